[sv/timer_queue_table_assert.svh]
// Assertion macros used by the timer queue table top level.
`ifndef TIMER_QUEUE_TABLE_ASSERT_SVH
`define TIMER_QUEUE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define TQT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TQT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TQT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TQT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[sv/tqt_pkg.sv]
// Types and constants of the timer queue table.
`timescale 1ns / 1ps
`default_nettype none
package tqt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] RK_ADDED     = 3'd0;
  localparam logic [2:0] RK_FULL      = 3'd1;
  localparam logic [2:0] RK_CANCELLED = 3'd2;
  localparam logic [2:0] RK_NOT_FOUND = 3'd3;
  localparam logic [2:0] RK_EXPIRED   = 3'd4;
  localparam logic [2:0] RK_TICK_DONE = 3'd5;

  localparam logic [62:0] MIN_WAIT = 63'd100;
  localparam logic [62:0] TIME_MAX = {63{1'b1}};

  typedef struct packed {
    logic [1:0]  operation;
    logic [62:0] expire_time;
    logic [47:0] repeat_interval;
    logic [3:0]  slot_id;
    logic [62:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  timer_slot;
    logic        earliest_changed;
    logic [62:0] next_deadline;
    logic        deadline_valid;
    logic [62:0] wait_time;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_SELECT,
    ST_PICK,
    ST_REARM,
    ST_MIN,
    ST_FINISH
  } tqt_state_t;

endpackage
`default_nettype wire

[sv/tqt_alu.sv]
// Shared add and subtract unit on 63-bit operands with a carry bit out, for the time compares and sums.
`timescale 1ns / 1ps
`default_nettype none
module tqt_alu (
  input  wire logic [62:0] op_a,
  input  wire logic [62:0] op_b,
  input  wire logic        op_sub,
  output logic      [63:0] sum
);

  logic [63:0] b_eff;

  assign b_eff = {1'b0, op_b} ^ {64{op_sub}};
  assign sum   = {1'b0, op_a} + b_eff + {63'd0, op_sub};

endmodule
`default_nettype wire

[sv/timer_queue_table.sv]
// Timer queue table: top level with slot storage and scan sequencer.
//
// An item is taken when start is high and busy is low. Operation add stores
// a timer in the lowest free slot, cancel frees a slot, and tick expires all
// timers due at now_time. Each result is shown on out_item for one cycle
// with out_strobe; the receiver cannot stall, so results are never held.
// Add and cancel give one beat; a tick gives one expired beat per due timer,
// in order of expiry and then of slot, and a final tick-done beat.
// Slot times live in a memory with one registered read port, and one shared
// adder does the time compares and sums, so each pass over the table handles
// one slot per cycle.
// busy stays high from accept until the final beat is issued; a new item
// may be accepted in the cycle that beat is shown.
// Reset empties the table at once; slot times need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_queue_table_assert.svh"
module timer_queue_table #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire tqt_pkg::in_item_t  in_item,
  output logic                    busy,
  output logic                    out_strobe,
  output tqt_pkg::out_item_t      out_item
);

  import tqt_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TIMER_SLOTS - 1);
  localparam logic [CW-1:0] SLOT_COUNT = CW'(TIMER_SLOTS);

  tqt_state_t state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [62:0]            exp_in_r, exp_in_nxt;
  logic [47:0]            per_in_r, per_in_nxt;
  logic [62:0]            now_r, now_nxt;
  logic [3:0]             cslot_r, cslot_nxt;
  logic [2:0]             ckind_r, ckind_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SW-1:0]          rd_idx_r;
  logic                   rd_vld_r;
  logic [TIMER_SLOTS-1:0] used_r, used_nxt;
  logic [TIMER_SLOTS-1:0] due_r, due_nxt;
  logic [TIMER_SLOTS-1:0] pend_r, pend_nxt;
  logic [62:0]            best_r, best_nxt;
  logic                   have_r, have_nxt;
  logic [SW-1:0]          pick_r, pick_nxt;
  logic [SW-1:0]          free_r, free_nxt;
  logic                   free_have_r, free_have_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_r, out_nxt;

  logic [62:0] exp_mem [TIMER_SLOTS];
  logic [47:0] per_mem [TIMER_SLOTS];
  logic [62:0] exp_q;
  logic [47:0] per_q;

  logic                   issue;
  logic [SW-1:0]          rd_addr;
  logic                   last_rd;
  logic                   exp_we, per_we;
  logic [SW-1:0]          waddr;
  logic [62:0]            exp_wdata;
  logic [TIMER_SLOTS-1:0] match;
  logic                   cancel_hit;
  logic                   chg;
  logic [62:0]            dl_out;
  logic [62:0]            alu_a, alu_b;
  logic                   alu_sub;
  logic [63:0]            alu_sum;
  logic [62:0]            sat_sum;

  tqt_alu u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .op_sub (alu_sub),
    .sum    (alu_sum)
  );

  assign rd_addr = cnt_r[SW-1:0];
  assign last_rd = rd_vld_r && (rd_idx_r == LAST_SLOT);
  assign sat_sum = alu_sum[63] ? TIME_MAX : alu_sum[62:0];
  assign dl_out  = have_r ? best_r : 63'd0;

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      match[i] = (32'(in_item.slot_id) == i);
    end
  end
  assign cancel_hit = |(match & used_r);

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[waddr] <= exp_wdata;
    end
    if (per_we) begin
      per_mem[waddr] <= per_in_r;
    end
    if (issue) begin
      exp_q <= exp_mem[rd_addr];
      per_q <= per_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      due_r        <= '0;
      pend_r       <= '0;
      rd_vld_r     <= 1'b0;
      cnt_r        <= '0;
      have_r       <= 1'b0;
      free_have_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      due_r        <= due_nxt;
      pend_r       <= pend_nxt;
      rd_vld_r     <= issue;
      cnt_r        <= cnt_nxt;
      have_r       <= have_nxt;
      free_have_r  <= free_have_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    exp_in_r <= exp_in_nxt;
    per_in_r <= per_in_nxt;
    now_r    <= now_nxt;
    cslot_r  <= cslot_nxt;
    ckind_r  <= ckind_nxt;
    rd_idx_r <= rd_addr;
    best_r   <= best_nxt;
    pick_r   <= pick_nxt;
    free_r   <= free_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    exp_in_nxt     = exp_in_r;
    per_in_nxt     = per_in_r;
    now_nxt        = now_r;
    cslot_nxt      = cslot_r;
    ckind_nxt      = ckind_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    due_nxt        = due_r;
    pend_nxt       = pend_r;
    best_nxt       = best_r;
    have_nxt       = have_r;
    pick_nxt       = pick_r;
    free_nxt       = free_r;
    free_have_nxt  = free_have_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    issue          = 1'b0;
    exp_we         = 1'b0;
    per_we         = 1'b0;
    waddr          = rd_idx_r;
    exp_wdata      = sat_sum;
    alu_a          = exp_q;
    alu_b          = best_r;
    alu_sub        = 1'b1;
    chg            = 1'b0;

    if (state_r == ST_MARK || state_r == ST_SELECT || state_r == ST_REARM ||
        state_r == ST_MIN) begin
      issue = (cnt_r < SLOT_COUNT);
      if (issue) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt        = in_item.operation;
          exp_in_nxt    = in_item.expire_time;
          per_in_nxt    = in_item.repeat_interval;
          now_nxt       = in_item.now_time;
          cslot_nxt     = in_item.slot_id;
          cnt_nxt       = '0;
          have_nxt      = 1'b0;
          free_have_nxt = 1'b0;
          case (in_item.operation)
            OP_ADD: begin
              state_nxt = ST_MIN;
            end
            OP_CANCEL: begin
              used_nxt  = used_r & ~match;
              ckind_nxt = cancel_hit ? RK_CANCELLED : RK_NOT_FOUND;
              state_nxt = ST_MIN;
            end
            OP_TICK: begin
              due_nxt   = '0;
              state_nxt = ST_MARK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MARK: begin
        alu_a = now_r;
        alu_b = exp_q;
        if (rd_vld_r) begin
          due_nxt[rd_idx_r] = used_r[rd_idx_r] && !alu_sum[63];
        end
        if (last_rd) begin
          pend_nxt  = due_nxt;
          cnt_nxt   = '0;
          have_nxt  = 1'b0;
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (rd_vld_r && pend_r[rd_idx_r] && (!have_r || alu_sum[63])) begin
          best_nxt = exp_q;
          pick_nxt = rd_idx_r;
          have_nxt = 1'b1;
        end
        if (last_rd) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        cnt_nxt = '0;
        if (have_r) begin
          out_strobe_nxt         = 1'b1;
          out_nxt.result_kind    = RK_EXPIRED;
          out_nxt.timer_slot     = 4'(pick_r);
          pend_nxt[pick_r]       = 1'b0;
          have_nxt               = 1'b0;
          state_nxt              = ST_SELECT;
        end else begin
          state_nxt = ST_REARM;
        end
      end
      ST_REARM: begin
        alu_a   = now_r;
        alu_b   = {15'd0, per_q};
        alu_sub = 1'b0;
        if (rd_vld_r && due_r[rd_idx_r]) begin
          if (per_q != 48'd0) begin
            exp_we = 1'b1;
          end else begin
            used_nxt[rd_idx_r] = 1'b0;
          end
        end
        if (last_rd) begin
          cnt_nxt       = '0;
          have_nxt      = 1'b0;
          free_have_nxt = 1'b0;
          state_nxt     = ST_MIN;
        end
      end
      ST_MIN: begin
        if (rd_vld_r) begin
          if (used_r[rd_idx_r] && (!have_r || alu_sum[63])) begin
            best_nxt = exp_q;
            have_nxt = 1'b1;
          end
          if (!used_r[rd_idx_r] && !free_have_r) begin
            free_nxt      = rd_idx_r;
            free_have_nxt = 1'b1;
          end
        end
        if (last_rd) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_strobe_nxt = 1'b1;
        out_nxt.last   = 1'b1;
        state_nxt      = ST_IDLE;
        case (op_r)
          OP_ADD: begin
            alu_a = exp_in_r;
            alu_b = best_r;
            chg   = !have_r || alu_sum[63];
            if (free_have_r) begin
              exp_we                   = 1'b1;
              per_we                   = 1'b1;
              waddr                    = free_r;
              exp_wdata                = exp_in_r;
              used_nxt[free_r]         = 1'b1;
              out_nxt.result_kind      = RK_ADDED;
              out_nxt.timer_slot       = 4'(free_r);
              out_nxt.earliest_changed = chg;
              out_nxt.next_deadline    = chg ? exp_in_r : best_r;
              out_nxt.deadline_valid   = 1'b1;
            end else begin
              out_nxt.result_kind    = RK_FULL;
              out_nxt.next_deadline  = dl_out;
              out_nxt.deadline_valid = have_r;
            end
          end
          OP_CANCEL: begin
            out_nxt.result_kind    = ckind_r;
            out_nxt.timer_slot     = cslot_r;
            out_nxt.next_deadline  = dl_out;
            out_nxt.deadline_valid = have_r;
          end
          default: begin
            alu_a                  = best_r;
            alu_b                  = now_r;
            out_nxt.result_kind    = RK_TICK_DONE;
            out_nxt.next_deadline  = dl_out;
            out_nxt.deadline_valid = have_r;
            if (!have_r) begin
              out_nxt.wait_time = 63'd0;
            end else if (alu_sum[63] || (alu_sum[62:0] < MIN_WAIT)) begin
              out_nxt.wait_time = MIN_WAIT;
            end else begin
              out_nxt.wait_time = alu_sum[62:0];
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  `TQT_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !busy && !out_strobe, "reset left block active")
  `TQT_ASSERT(a_last_frees, clk, rst_n, out_strobe && out_item.last |-> !busy, "busy after final beat")
  `TQT_ASSERT(a_fell_last, clk, rst_n, $fell(busy) |-> out_strobe && out_item.last, "item ended without final beat")
  `TQT_ASSERT(a_accept_quiet, clk, rst_n, start && !busy |=> !out_strobe, "beat right after accept")
  `TQT_ASSERT(a_pend_due, clk, rst_n, (pend_r & ~due_r) == '0, "pending timer not due")

endmodule
`default_nettype wire

[tb/timer_queue_table_tb.sv]
// Self-checking testbench for the timer queue table: adds, cancels and ticks.
`timescale 1ns / 1ps
module timer_queue_table_tb;
  import tqt_pkg::*;

  localparam int SLOTS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [47:0] PERIOD_MAX = {48{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic out_strobe;
  out_item_t out_item;

  out_item_t awaited_results[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  logic [62:0] clock_us = 63'd10000;

  logic tbl_used [SLOTS];
  logic [62:0] tbl_expiry [SLOTS];
  logic [47:0] tbl_period [SLOTS];

  timer_queue_table #(.TIMER_SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .out_strobe(out_strobe),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic logic [62:0] rand63();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[62:0];
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation = 2'($urandom_range(0, 3));
    it.expire_time = rand63();
    it.repeat_interval = rand48();
    it.slot_id = 4'($urandom_range(0, 15));
    it.now_time = rand63();
    return it;
  endfunction

  function automatic logic [62:0] earliest_armed(output bit any);
    logic [62:0] best;
    best = '0;
    any = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i] && (!any || tbl_expiry[i] < best)) begin
        best = tbl_expiry[i];
        any = 1'b1;
      end
    end
    return best;
  endfunction

  task automatic compute_timer_results(input in_item_t it);
    out_item_t r;
    logic [62:0] old_dl;
    logic [62:0] dl;
    logic [62:0] wt;
    logic [63:0] sum;
    bit had;
    bit dv;
    bit due [SLOTS];
    int free_slot;
    int pick;
    r = '0;
    case (it.operation)
      OP_ADD: begin
        old_dl = earliest_armed(had);
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tbl_used[i]) free_slot = i;
        end
        r.last = 1'b1;
        if (free_slot < 0) begin
          r.result_kind = RK_FULL;
          r.next_deadline = old_dl;
          r.deadline_valid = had;
        end else begin
          r.earliest_changed = !had || (it.expire_time < old_dl);
          tbl_used[free_slot] = 1'b1;
          tbl_expiry[free_slot] = it.expire_time;
          tbl_period[free_slot] = it.repeat_interval;
          r.result_kind = RK_ADDED;
          r.timer_slot = 4'(free_slot);
          r.next_deadline = earliest_armed(dv);
          r.deadline_valid = dv;
        end
        awaited_results.push_back(r);
      end
      OP_CANCEL: begin
        r.result_kind = RK_NOT_FOUND;
        if (tbl_used[it.slot_id]) begin
          tbl_used[it.slot_id] = 1'b0;
          r.result_kind = RK_CANCELLED;
        end
        r.timer_slot = it.slot_id;
        r.next_deadline = earliest_armed(dv);
        r.deadline_valid = dv;
        r.last = 1'b1;
        awaited_results.push_back(r);
      end
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          due[i] = tbl_used[i] && (tbl_expiry[i] <= it.now_time);
        end
        for (int n = 0; n < SLOTS; n++) begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (due[i] && (pick < 0 || tbl_expiry[i] < tbl_expiry[pick])) pick = i;
          end
          if (pick < 0) break;
          due[pick] = 1'b0;
          r = '0;
          r.result_kind = RK_EXPIRED;
          r.timer_slot = 4'(pick);
          awaited_results.push_back(r);
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_used[i] && (tbl_expiry[i] <= it.now_time)) begin
            if (tbl_period[i] != '0) begin
              sum = {1'b0, it.now_time} + {16'b0, tbl_period[i]};
              tbl_expiry[i] = sum[63] ? TIME_MAX : sum[62:0];
            end else begin
              tbl_used[i] = 1'b0;
            end
          end
        end
        dl = earliest_armed(dv);
        wt = '0;
        if (dv) begin
          wt = (dl > it.now_time) ? dl - it.now_time : '0;
          if (wt < MIN_WAIT) wt = MIN_WAIT;
        end
        r = '0;
        r.result_kind = RK_TICK_DONE;
        r.next_deadline = dl;
        r.deadline_valid = dv;
        r.wait_time = wt;
        r.last = 1'b1;
        awaited_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [62:0] want, input logic [62:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0d slot %0d",
             got.result_kind, got.timer_slot);
      error_count++;
    end else begin
      want = awaited_results.pop_front();
      check_field("result_kind", 63'(want.result_kind), 63'(got.result_kind));
      check_field("timer_slot", 63'(want.timer_slot), 63'(got.timer_slot));
      check_field("earliest_changed", 63'(want.earliest_changed), 63'(got.earliest_changed));
      check_field("next_deadline", want.next_deadline, got.next_deadline);
      check_field("deadline_valid", 63'(want.deadline_valid), 63'(got.deadline_valid));
      check_field("wait_time", want.wait_time, got.wait_time);
      check_field("last", 63'(want.last), 63'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) check_beat(out_item);
      if (start && !busy) compute_timer_results(in_item);
      if ((start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_add(input logic [62:0] expiry, input logic [47:0] period);
    in_item_t it;
    it = rand_item();
    it.operation = OP_ADD;
    it.expire_time = expiry;
    it.repeat_interval = period;
    send_item(it);
  endtask

  task automatic send_cancel(input logic [3:0] slot);
    in_item_t it;
    it = rand_item();
    it.operation = OP_CANCEL;
    it.slot_id = slot;
    send_item(it);
  endtask

  task automatic send_tick(input logic [62:0] now);
    in_item_t it;
    it = rand_item();
    it.operation = OP_TICK;
    it.now_time = now;
    send_item(it);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_tick('0);
    send_cancel(4'd0);
  endtask

  task automatic test_add_cancel();
    in_item_t it;
    send_add(63'd1000, '0);
    send_add(63'd1000, 48'd500);
    send_add(TIME_MAX, PERIOD_MAX);
    send_add('0, '0);
    send_cancel(4'd3);
    send_cancel(4'd3);
    send_cancel(4'd15);
    it = rand_item();
    it.operation = 2'b11;
    send_item(it);
  endtask

  task automatic test_tick_order();
    send_tick(63'd999);
    send_add(63'd1100, '0);
    send_tick(63'd1000);
    send_tick(63'd1600);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS - 2; i++) begin
      send_add(63'd2000 + 63'($urandom_range(0, 4000)),
               ($urandom_range(0, 1) == 0) ? '0 : 48'($urandom_range(1, 3000)));
    end
    send_add(63'd1, 48'd1);
    send_tick(TIME_MAX);
  endtask

  task automatic test_random_traffic(input int count);
    int sel;
    int used_slots[$];
    logic [62:0] expiry;
    logic [47:0] period;
    in_item_t it;
    for (int n = 0; n < SLOTS; n++) send_cancel(4'(n));
    for (int n = 0; n < count; n++) begin
      idle_on = (n < count - 30);
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
        expiry = ($urandom_range(0, 11) == 0) ? rand63()
                 : clock_us + 63'($urandom_range(0, 6000));
        case ($urandom_range(0, 11))
          0, 1, 2, 3: period = '0;
          4: period = rand48();
          default: period = 48'($urandom_range(1, 3000));
        endcase
        send_add(expiry, period);
      end else if (sel < 13) begin
        used_slots.delete();
        for (int i = 0; i < SLOTS; i++) if (tbl_used[i]) used_slots.push_back(i);
        if (used_slots.size() != 0 && $urandom_range(0, 4) != 0) begin
          send_cancel(4'(used_slots[$urandom_range(0, used_slots.size() - 1)]));
        end else begin
          send_cancel(4'($urandom_range(0, 15)));
        end
      end else if (sel < 19) begin
        if ($urandom_range(0, 11) == 0) begin
          send_tick(rand63());
        end else begin
          clock_us = clock_us + 63'($urandom_range(0, 3000));
          send_tick(clock_us);
        end
      end else begin
        it = rand_item();
        it.operation = 2'b11;
        send_item(it);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_expiry[i] = '0;
      tbl_period[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_add_cancel();
    test_tick_order();
    test_full_table();
    hold_until_drained();
    test_random_traffic(110);
    hold_until_drained();
    repeat (60) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d expected result beats never arrived", awaited_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[timer_queue_table.f]
+incdir+sv
sv/tqt_pkg.sv
sv/tqt_alu.sv
sv/timer_queue_table.sv
tb/timer_queue_table_tb.sv
